>>> sv/ffam_pkg.sv
// ----------------------------------------------------------------------------
// ffam_pkg
// shared types, constants and step tables for the floor field agent mover
// ----------------------------------------------------------------------------
package ffam_pkg;

  localparam int COORD_BITS  = 6;
  localparam int EXIT_BITS   = 2;
  localparam int FIELD_BITS  = 16;
  localparam int DIM_BITS    = 7;
  localparam int CELL_BITS   = 2 * COORD_BITS;
  localparam int FADDR_BITS  = EXIT_BITS + CELL_BITS;
  localparam int CELLS       = 1 << CELL_BITS;
  localparam int FIELD_DEPTH = 1 << FADDR_BITS;
  localparam int THR_BITS    = FIELD_BITS + 1;

  localparam logic [DIM_BITS-1:0] MAX_DIM = DIM_BITS'(1 << COORD_BITS);

  localparam logic [1:0] OP_WR_FIELD = 2'd0;
  localparam logic [1:0] OP_WR_OCC   = 2'd1;
  localparam logic [1:0] OP_MOVE     = 2'd2;

  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_OBST_WEIGHT = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_OWN,
    ST_SCAN,
    ST_PICK,
    ST_WR_OLD,
    ST_WR_NEW
  } state_t;

  typedef struct packed {
    logic                wr;
    logic [2:0]          slot;
    logic [THR_BITS-1:0] thr;
    logic [3:0]          count;
  } eval_t;

  // neighbour order: right, left, up, down, upper-right, lower-left,
  // lower-right, upper-left
  function automatic logic [DIM_BITS-1:0] step_dx(input logic [2:0] k);
    logic [DIM_BITS-1:0] d;
    case (k)
      3'd0, 3'd4, 3'd6: d = DIM_BITS'(1);
      3'd1, 3'd5, 3'd7: d = '1;
      default:          d = '0;
    endcase
    return d;
  endfunction

  function automatic logic [DIM_BITS-1:0] step_dy(input logic [2:0] k);
    logic [DIM_BITS-1:0] d;
    case (k)
      3'd2, 3'd4, 3'd7: d = DIM_BITS'(1);
      3'd3, 3'd5, 3'd6: d = '1;
      default:          d = '0;
    endcase
    return d;
  endfunction

endpackage

>>> sv/ffam_eval.sv
// ----------------------------------------------------------------------------
// ffam_eval
// shared compare unit: folds one neighbour field value into the candidate set
// ----------------------------------------------------------------------------
module ffam_eval (
  input  logic [ffam_pkg::FIELD_BITS-1:0] field,
  input  logic [ffam_pkg::FIELD_BITS-1:0] own,
  input  logic [ffam_pkg::THR_BITS-1:0]   thr,
  input  logic [3:0]                      count,
  output ffam_pkg::eval_t                 res
);

  logic [ffam_pkg::THR_BITS-1:0] v;
  logic lt;
  logic eq;

  assign v  = {1'b0, field};
  assign lt = $signed(v) < $signed(thr);
  assign eq = (v == thr) && (field != own);

  always_comb begin
    res.wr    = lt || eq;
    res.slot  = lt ? 3'd0 : count[2:0];
    res.thr   = lt ? v : thr;
    res.count = lt ? 4'd1 : (eq ? count + 4'd1 : count);
  end

endmodule

>>> sv/floor_field_agent_move.sv
// ----------------------------------------------------------------------------
// floor_field_agent_move
// floor field cellular automaton: grid loading and single agent moves
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Opcode 0 writes one
// floor field entry, opcode 1 writes one cell's occupancy, opcode 2 moves the
// agent at (cell_x, cell_y) toward exit exit_index; other codes change
// nothing. Every item gives one result, shown for one cycle with done high.
// Write items: the write is made in the execute state, then the result is
// registered. Moves: one own-cell read, then the eight neighbours one per
// cycle through the single-port field and occupancy memories and the shared
// compare unit, a candidate pick and two occupancy write-backs; the result is
// registered after the last write-back (after the pick when no neighbour
// qualifies, after the execute state when no move is attempted). busy is low
// during the cycle the result is shown, so the next item can be taken while
// it is shown. After reset the occupancy memory is cleared one cell per cycle;
// busy stays high until all cells are clear. Configuration writes go through
// the APB port; the user makes them only while no item is in flight, which
// the block does not enforce. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module floor_field_agent_move (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        opcode,
  input  logic [ffam_pkg::COORD_BITS-1:0]   cell_x,
  input  logic [ffam_pkg::COORD_BITS-1:0]   cell_y,
  input  logic [ffam_pkg::EXIT_BITS-1:0]    exit_index,
  input  logic [ffam_pkg::FIELD_BITS-1:0]   field_value,
  input  logic                              occupied,
  input  logic [7:0]                        rand_fraction,
  output logic                              done,
  output logic [ffam_pkg::COORD_BITS-1:0]   new_x,
  output logic [ffam_pkg::COORD_BITS-1:0]   new_y,
  output logic                              moved,
  output logic [3:0]                        candidate_count,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  ffam_pkg::state_t state, state_next;

  logic [ffam_pkg::DIM_BITS-1:0]   grid_width, grid_height;
  logic [ffam_pkg::FIELD_BITS-1:0] wall_cost;
  logic [ffam_pkg::DIM_BITS-1:0]   w_eff, h_eff;

  logic [ffam_pkg::CELL_BITS-1:0]  clr_cnt;
  logic [3:0]                      k;
  logic [1:0]                      op_r;
  logic [ffam_pkg::COORD_BITS-1:0] x_r, y_r;
  logic [ffam_pkg::EXIT_BITS-1:0]  ex_r;
  logic [ffam_pkg::FIELD_BITS-1:0] fv_r;
  logic                            occ_r;
  logic [7:0]                      rnd_r;

  logic [ffam_pkg::FIELD_BITS-1:0] own;
  logic [ffam_pkg::THR_BITS-1:0]   thr;
  logic [3:0]                      count;
  logic [2:0]                      cand [8];
  logic [2:0]                      sel_k;
  logic                            prev_ok;

  logic [ffam_pkg::FIELD_BITS-1:0] fld_mem [ffam_pkg::FIELD_DEPTH];
  logic                            occ_mem [ffam_pkg::CELLS];
  logic [ffam_pkg::FIELD_BITS-1:0] fld_q;
  logic                            occ_q;
  logic [ffam_pkg::FADDR_BITS-1:0] fld_addr;
  logic                            fld_we;
  logic [ffam_pkg::CELL_BITS-1:0]  occ_addr;
  logic                            occ_we;
  logic                            occ_wd;

  logic [2:0]                      nk;
  logic [ffam_pkg::DIM_BITS-1:0]   nx, ny;
  logic                            inb;
  logic                            qualify;
  logic [10:0]                     prod;
  ffam_pkg::eval_t                 ev;

  logic                            accept;
  logic                            cfg_wr;
  logic                            done_next;
  logic [ffam_pkg::COORD_BITS-1:0] new_x_next, new_y_next;
  logic                            moved_next;
  logic [3:0]                      count_next;

  assign accept = start && !busy;
  assign busy   = (state != ffam_pkg::ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= ffam_pkg::MAX_DIM;
      grid_height <= ffam_pkg::MAX_DIM;
      wall_cost   <= '1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        ffam_pkg::REG_GRID_WIDTH:  grid_width  <= pwdata[ffam_pkg::DIM_BITS-1:0];
        ffam_pkg::REG_GRID_HEIGHT: grid_height <= pwdata[ffam_pkg::DIM_BITS-1:0];
        ffam_pkg::REG_OBST_WEIGHT: wall_cost   <= pwdata[ffam_pkg::FIELD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ffam_pkg::REG_GRID_WIDTH:  prdata = 32'(grid_width);
      ffam_pkg::REG_GRID_HEIGHT: prdata = 32'(grid_height);
      ffam_pkg::REG_OBST_WEIGHT: prdata = 32'(wall_cost);
      default:                   prdata = '0;
    endcase
  end

  assign w_eff = (grid_width  > ffam_pkg::MAX_DIM) ? ffam_pkg::MAX_DIM : grid_width;
  assign h_eff = (grid_height > ffam_pkg::MAX_DIM) ? ffam_pkg::MAX_DIM : grid_height;

  // neighbour coordinate unit
  assign nk  = (state == ffam_pkg::ST_WR_NEW) ? sel_k : k[2:0];
  assign nx  = {1'b0, x_r} + ffam_pkg::step_dx(nk);
  assign ny  = {1'b0, y_r} + ffam_pkg::step_dy(nk);
  assign inb = !nx[ffam_pkg::DIM_BITS-1] && !ny[ffam_pkg::DIM_BITS-1] &&
               (nx < w_eff) && (ny < h_eff);

  assign qualify = (state == ffam_pkg::ST_SCAN) && (k != 4'd0) && prev_ok && !occ_q;
  assign prod    = {3'b0, rnd_r} * {7'b0, count};

  ffam_eval u_eval (
    .field (fld_q),
    .own   (own),
    .thr   (thr),
    .count (count),
    .res   (ev)
  );

  // memories
  always_ff @(posedge clk) begin
    if (fld_we) begin
      fld_mem[fld_addr] <= fv_r;
    end
    fld_q <= fld_mem[fld_addr];
  end

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_addr] <= occ_wd;
    end
    occ_q <= occ_mem[occ_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffam_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    fld_addr   = {ex_r, ny[ffam_pkg::COORD_BITS-1:0], nx[ffam_pkg::COORD_BITS-1:0]};
    fld_we     = 1'b0;
    occ_addr   = {ny[ffam_pkg::COORD_BITS-1:0], nx[ffam_pkg::COORD_BITS-1:0]};
    occ_we     = 1'b0;
    occ_wd     = 1'b0;
    done_next  = 1'b0;
    new_x_next = x_r;
    new_y_next = y_r;
    moved_next = 1'b0;
    count_next = 4'd0;
    case (state)
      ffam_pkg::ST_CLEAR: begin
        occ_addr = clr_cnt;
        occ_we   = 1'b1;
        if (clr_cnt == '1) begin
          state_next = ffam_pkg::ST_IDLE;
        end
      end
      ffam_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = ffam_pkg::ST_EXEC;
        end
      end
      ffam_pkg::ST_EXEC: begin
        fld_addr = {ex_r, y_r, x_r};
        occ_addr = {y_r, x_r};
        occ_wd   = occ_r;
        fld_we   = (op_r == ffam_pkg::OP_WR_FIELD);
        occ_we   = (op_r == ffam_pkg::OP_WR_OCC);
        if ((op_r == ffam_pkg::OP_MOVE) && ({1'b0, x_r} < w_eff) && ({1'b0, y_r} < h_eff)) begin
          state_next = ffam_pkg::ST_OWN;
        end else begin
          done_next  = 1'b1;
          state_next = ffam_pkg::ST_IDLE;
        end
      end
      ffam_pkg::ST_OWN: begin
        fld_addr   = {ex_r, y_r, x_r};
        state_next = ffam_pkg::ST_SCAN;
      end
      ffam_pkg::ST_SCAN: begin
        if (k == 4'd8) begin
          state_next = ffam_pkg::ST_PICK;
        end
      end
      ffam_pkg::ST_PICK: begin
        if (count == 4'd0) begin
          done_next  = 1'b1;
          state_next = ffam_pkg::ST_IDLE;
        end else begin
          state_next = ffam_pkg::ST_WR_OLD;
        end
      end
      ffam_pkg::ST_WR_OLD: begin
        occ_addr   = {y_r, x_r};
        occ_we     = 1'b1;
        state_next = ffam_pkg::ST_WR_NEW;
      end
      ffam_pkg::ST_WR_NEW: begin
        occ_we     = 1'b1;
        occ_wd     = 1'b1;
        done_next  = 1'b1;
        new_x_next = nx[ffam_pkg::COORD_BITS-1:0];
        new_y_next = ny[ffam_pkg::COORD_BITS-1:0];
        moved_next = 1'b1;
        count_next = count;
        state_next = ffam_pkg::ST_IDLE;
      end
      default: begin
        state_next = ffam_pkg::ST_IDLE;
      end
    endcase
  end

  // item capture and scan datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ffam_pkg::ST_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= opcode;
      x_r   <= cell_x;
      y_r   <= cell_y;
      ex_r  <= exit_index;
      fv_r  <= field_value;
      occ_r <= occupied;
      rnd_r <= rand_fraction;
    end
    case (state)
      ffam_pkg::ST_OWN: begin
        k     <= 4'd0;
        thr   <= {1'b0, wall_cost} - ffam_pkg::THR_BITS'(1);
        count <= 4'd0;
      end
      ffam_pkg::ST_SCAN: begin
        k       <= k + 4'd1;
        prev_ok <= inb;
        if (k == 4'd0) begin
          own <= fld_q;
        end
        if (qualify && ev.wr) begin
          cand[ev.slot] <= 3'(k - 4'd1);
          thr           <= ev.thr;
          count         <= ev.count;
        end
      end
      ffam_pkg::ST_PICK: begin
        sel_k <= cand[prod[10:8]];
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
    if (done_next) begin
      new_x           <= new_x_next;
      new_y           <= new_y_next;
      moved           <= moved_next;
      candidate_count <= count_next;
    end
  end

endmodule

>>> sv/ffam_checker.sv
// ----------------------------------------------------------------------------
// ffam_checker
// port-level checks on the item and result timing of the agent mover
// ----------------------------------------------------------------------------
module ffam_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic                            moved,
  input logic [3:0]                      candidate_count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("item taken but block not busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without work in progress");

  a_moved_count: assert property (@(posedge clk) disable iff (rst)
    done && moved |-> (candidate_count != 4'd0) && (candidate_count <= 4'd8))
    else $error("move without a valid candidate count");

  a_still_count: assert property (@(posedge clk) disable iff (rst)
    done && !moved |-> candidate_count == 4'd0)
    else $error("candidates found but agent did not move");

endmodule

bind floor_field_agent_move ffam_checker u_ffam_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .moved           (moved),
  .candidate_count (candidate_count)
);
